// ----- rtl/core/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// Segmented prime sieve counter package
// Shared constants, default parameter values and the transaction payload
// types of the segmented prime sieve counter.
// ----------------------------------------------------------------------------
package sps_pkg;

    // Default configuration of the block.
    localparam int VALUE_BITS_DEF = 24;
    localparam int SPAN_MAX_DEF   = 65536;
    localparam int ROOT_MAX_DEF   = 4097;

    // Smallest prime; values below it are never counted.
    localparam int FIRST_PRIME = 2;

    // Fixed field widths of the transactions.
    localparam int RANGE_W = 24;
    localparam int COUNT_W = 17;

    typedef struct packed {
        logic [RANGE_W-1:0] range_low;
        logic [RANGE_W-1:0] range_high;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] prime_count;
        logic               range_error;
    } out_item_t;

endpackage

// ----- rtl/core/sps_isqrt.sv -----
// ----------------------------------------------------------------------------
// Iterative integer square root
// Finds the largest r with r*r <= n, one result bit per cycle, using a single
// multiplier and compare.
// ----------------------------------------------------------------------------
module sps_isqrt #(
    parameter int VB = sps_pkg::VALUE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [VB-1:0] n,
    output logic          done,
    output logic [(VB+1)/2-1:0] root
);
    import sps_pkg::*;

    localparam int RB = (VB + 1) / 2;

    logic [RB-1:0]   bit_reg,  bit_next;
    logic [RB-1:0]   root_reg, root_next;
    logic            done_reg, done_next;
    logic [RB-1:0]   trial;
    logic [2*RB-1:0] trial_sq;

    assign trial    = root_reg | bit_reg;
    assign trial_sq = (2*RB)'(trial) * (2*RB)'(trial);

    always_comb
    begin
        bit_next  = bit_reg;
        root_next = root_reg;
        done_next = 1'b0;
        if (start)
        begin
            bit_next  = RB'(1) << (RB - 1);
            root_next = '0;
        end
        else if (bit_reg != '0)
        begin
            if (trial_sq <= (2*RB)'(n))
            begin
                root_next = trial;
            end
            bit_next  = bit_reg >> 1;
            done_next = (bit_reg == RB'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            bit_reg  <= bit_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/core/sps_mod.sv -----
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Restoring division that produces dividend mod divisor, one dividend bit
// per cycle.
// ----------------------------------------------------------------------------
module sps_mod #(
    parameter int VB = sps_pkg::VALUE_BITS_DEF,
    parameter int LW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [VB-1:0] dividend,
    input  logic [LW-1:0] divisor,
    output logic          done,
    output logic [LW-1:0] rem
);
    import sps_pkg::*;

    localparam int NW = $clog2(VB + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NW-1:0] cnt_reg,  cnt_next;
    logic [VB-1:0] dvd_reg,  dvd_next;
    logic [LW-1:0] rem_reg,  rem_next;
    logic [LW:0]   trial;
    logic [LW:0]   diff;

    assign trial = {rem_reg, dvd_reg[VB-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = NW'(VB);
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so the trial
            // value fits one bit wider than the divisor.
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[LW-1:0];
            end
            else
            begin
                rem_next = trial[LW-1:0];
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - NW'(1);
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/core/sps_core.sv -----
// ----------------------------------------------------------------------------
// Sieve sequencer
// Owns both flag memories and walks them: refill, small sieve, marking of
// multiples inside the range, and the final count of unmarked values.
// ----------------------------------------------------------------------------
module sps_core #(
    parameter int VB       = sps_pkg::VALUE_BITS_DEF,
    parameter int SPAN_MAX = sps_pkg::SPAN_MAX_DEF,
    parameter int ROOT_MAX = sps_pkg::ROOT_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [VB-1:0]                 lo,
    input  logic [VB-1:0]                 hi,
    input  logic [$clog2(SPAN_MAX+1)-1:0] span,
    output logic                          done,
    output logic [$clog2(SPAN_MAX+1)-1:0] count
);
    import sps_pkg::*;

    localparam int RB = (VB + 1) / 2;
    localparam int AW = $clog2(SPAN_MAX);
    localparam int SW = $clog2(SPAN_MAX + 1);
    localparam int RW = $clog2(ROOT_MAX);
    localparam int LW = $clog2(ROOT_MAX + 1);
    localparam int JW = ((VB > LW) ? VB : LW) + 2;

    localparam logic [3:0] C_IDLE      = 4'd0;
    localparam logic [3:0] C_SQRT      = 4'd1;
    localparam logic [3:0] C_CLR_RANGE = 4'd2;
    localparam logic [3:0] C_CLR_ROOT  = 4'd3;
    localparam logic [3:0] C_SS_READ   = 4'd4;
    localparam logic [3:0] C_SS_TEST   = 4'd5;
    localparam logic [3:0] C_SS_MARK   = 4'd6;
    localparam logic [3:0] C_MK_READ   = 4'd7;
    localparam logic [3:0] C_MK_TEST   = 4'd8;
    localparam logic [3:0] C_MK_DIV    = 4'd9;
    localparam logic [3:0] C_MK_FIX    = 4'd10;
    localparam logic [3:0] C_MK_MARK   = 4'd11;
    localparam logic [3:0] C_CNT       = 4'd12;
    localparam logic [3:0] C_DONE      = 4'd13;

    logic [3:0]    state_reg,   state_next;
    logic [SW-1:0] k_reg,       k_next;
    logic [LW-1:0] i_reg,       i_next;
    logic [JW-1:0] sq_reg,      sq_next;
    logic [JW-1:0] j_reg,       j_next;
    logic [LW-1:0] limit_reg,   limit_next;
    logic [SW-1:0] count_reg,   count_next;
    logic          pend_reg,    pend_next;
    logic          pend_ok_reg, pend_ok_next;

    // Flag memories, one write and one registered read port each.
    logic          range_mem [SPAN_MAX];
    logic          root_mem  [ROOT_MAX];
    logic          range_rd_reg;
    logic          root_rd_reg;
    logic          range_we;
    logic [AW-1:0] range_waddr;
    logic          range_wdata;
    logic          root_we;
    logic [RW-1:0] root_waddr;
    logic          root_wdata;

    logic          sqrt_start;
    logic          sqrt_done;
    logic [RB-1:0] sqrt_root;
    logic          div_start;
    logic          div_done;
    logic [LW-1:0] div_rem;

    logic [JW-1:0] lim_wide;
    logic [JW-1:0] i_wide;
    logic [JW-1:0] lo_wide;
    logic [JW-1:0] two_i;
    logic [JW-1:0] base;
    logic [JW-1:0] offset;

    assign sqrt_start = (state_reg == C_IDLE) && start;
    assign div_start  = (state_reg == C_MK_TEST) && root_rd_reg;

    sps_isqrt #(
        .VB (VB)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .n     (hi),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    sps_mod #(
        .VB (VB),
        .LW (LW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lo),
        .divisor  (i_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign lim_wide = JW'(sqrt_root) + JW'(1);
    assign i_wide   = JW'(i_reg);
    assign lo_wide  = JW'(lo);
    assign two_i    = i_wide << 1;
    assign base     = (div_rem == '0) ? lo_wide : lo_wide + i_wide - JW'(div_rem);
    assign offset   = j_reg - lo_wide;

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        sq_next      = sq_reg;
        j_next       = j_reg;
        limit_next   = limit_reg;
        count_next   = count_reg;
        pend_next    = 1'b0;
        pend_ok_next = 1'b0;
        range_we     = 1'b0;
        range_waddr  = k_reg[AW-1:0];
        range_wdata  = 1'b1;
        root_we      = 1'b0;
        root_waddr   = i_reg[RW-1:0];
        root_wdata   = 1'b1;

        // Count a value read during the previous cycle.
        if (pend_reg && pend_ok_reg && range_rd_reg)
        begin
            count_next = count_reg + SW'(1);
        end

        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    count_next = '0;
                    state_next = C_SQRT;
                end
            end

            C_SQRT:
            begin
                if (sqrt_done)
                begin
                    if (lim_wide > JW'(ROOT_MAX))
                    begin
                        limit_next = LW'(ROOT_MAX);
                    end
                    else
                    begin
                        limit_next = LW'(lim_wide);
                    end
                    k_next     = '0;
                    state_next = C_CLR_RANGE;
                end
            end

            C_CLR_RANGE:
            begin
                if (k_reg < span)
                begin
                    range_we = 1'b1;
                    k_next   = k_reg + SW'(1);
                end
                else
                begin
                    i_next     = '0;
                    state_next = C_CLR_ROOT;
                end
            end

            C_CLR_ROOT:
            begin
                if (i_reg < limit_reg)
                begin
                    root_we = 1'b1;
                    i_next  = i_reg + LW'(1);
                end
                else
                begin
                    i_next     = LW'(FIRST_PRIME);
                    sq_next    = JW'(FIRST_PRIME * FIRST_PRIME);
                    state_next = C_SS_READ;
                end
            end

            C_SS_READ:
            begin
                if (sq_reg < JW'(limit_reg))
                begin
                    state_next = C_SS_TEST;
                end
                else
                begin
                    i_next     = LW'(FIRST_PRIME);
                    state_next = C_MK_READ;
                end
            end

            C_SS_TEST:
            begin
                if (root_rd_reg)
                begin
                    j_next     = sq_reg;
                    state_next = C_SS_MARK;
                end
                else
                begin
                    i_next     = i_reg + LW'(1);
                    sq_next    = sq_reg + two_i + JW'(1);
                    state_next = C_SS_READ;
                end
            end

            C_SS_MARK:
            begin
                if (j_reg < JW'(limit_reg))
                begin
                    root_we    = 1'b1;
                    root_waddr = j_reg[RW-1:0];
                    root_wdata = 1'b0;
                    j_next     = j_reg + i_wide;
                end
                else
                begin
                    i_next     = i_reg + LW'(1);
                    sq_next    = sq_reg + two_i + JW'(1);
                    state_next = C_SS_READ;
                end
            end

            C_MK_READ:
            begin
                if (i_reg < limit_reg)
                begin
                    state_next = C_MK_TEST;
                end
                else
                begin
                    k_next     = '0;
                    state_next = C_CNT;
                end
            end

            C_MK_TEST:
            begin
                if (root_rd_reg)
                begin
                    state_next = C_MK_DIV;
                end
                else
                begin
                    i_next     = i_reg + LW'(1);
                    state_next = C_MK_READ;
                end
            end

            C_MK_DIV:
            begin
                if (div_done)
                begin
                    j_next     = base;
                    state_next = C_MK_FIX;
                end
            end

            C_MK_FIX:
            begin
                // A prime itself is never marked.
                if (j_reg < two_i)
                begin
                    j_next = two_i;
                end
                state_next = C_MK_MARK;
            end

            C_MK_MARK:
            begin
                if (j_reg <= JW'(hi))
                begin
                    range_we    = 1'b1;
                    range_waddr = offset[AW-1:0];
                    range_wdata = 1'b0;
                    j_next      = j_reg + i_wide;
                end
                else
                begin
                    i_next     = i_reg + LW'(1);
                    state_next = C_MK_READ;
                end
            end

            C_CNT:
            begin
                if (k_reg < span)
                begin
                    pend_next    = 1'b1;
                    pend_ok_next = (lo_wide + JW'(k_reg)) >= JW'(FIRST_PRIME);
                    k_next       = k_reg + SW'(1);
                end
                else
                begin
                    state_next = C_DONE;
                end
            end

            C_DONE:
            begin
                state_next = C_IDLE;
            end

            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        i_reg       <= i_next;
        sq_reg      <= sq_next;
        j_reg       <= j_next;
        limit_reg   <= limit_next;
        count_reg   <= count_next;
        pend_ok_reg <= pend_ok_next;
    end

    always_ff @(posedge clk)
    begin
        if (range_we)
        begin
            range_mem[range_waddr] <= range_wdata;
        end
        range_rd_reg <= range_mem[k_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (root_we)
        begin
            root_mem[root_waddr] <= root_wdata;
        end
        root_rd_reg <= root_mem[i_reg[RW-1:0]];
    end

    assign done  = (state_reg == C_DONE);
    assign count = count_reg;

endmodule

// ----- rtl/core/segmented_prime_sieve_count_top.sv -----
// ----------------------------------------------------------------------------
// Segmented prime sieve counter, top level
// Counts the primes in an inclusive range with a segmented sieve of
// Eratosthenes built around one sequencer and two flag memories.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction on in_valid/in_ready carries range_low and
// range_high. Exactly one result transaction on out_valid/out_ready follows,
// carrying prime_count and range_error. The block takes one request at a time:
// in_ready is high only while no request is in progress.
// A reversed range, or one wider than SPAN_MAX values, returns range_error
// set and a zero count without running the sieve. Otherwise the run time is
// set by the flag memories, which the refill and marking passes write and
// the counting pass reads once per cycle, and by the bit-serial remainder
// unit run once per prime.
// Reset returns both state machines to idle and drops out_valid; the flag
// memories are refilled at the start of every request, so reset needs no
// clearing pass. A stalled receiver holds the result in the output register.
// A new request is accepted as soon as a result is loaded there, but its own
// result waits until the register is free.
// ----------------------------------------------------------------------------
module segmented_prime_sieve_count_top #(
    parameter int VALUE_BITS = sps_pkg::VALUE_BITS_DEF,
    parameter int SPAN_MAX   = sps_pkg::SPAN_MAX_DEF,
    parameter int ROOT_MAX   = sps_pkg::ROOT_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sps_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sps_pkg::out_item_t out_data
);
    import sps_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam int SW = $clog2(SPAN_MAX + 1);
    // Wide enough for both the range width and the store size.
    localparam int EW = (((VB + 1) > SW) ? (VB + 1) : SW) + 1;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_RUN  = 2'd1;
    localparam logic [1:0] T_HOLD = 2'd2;

    logic [1:0]    state_reg,     state_next;
    logic [VB-1:0] lo_reg,        lo_next;
    logic [VB-1:0] hi_reg,        hi_next;
    logic [SW-1:0] span_reg,      span_next;
    logic          err_reg,       err_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg,  out_data_next;

    // Inputs are cut to the configured value width before use.
    logic [VB-1:0] lo_in;
    logic [VB-1:0] hi_in;
    logic [EW-1:0] span_wide;
    logic          range_bad;
    logic          accept;
    logic          out_free;

    logic          core_start;
    logic          core_done;
    logic [SW-1:0] core_count;

    assign lo_in     = VB'(in_data.range_low);
    assign hi_in     = VB'(in_data.range_high);
    assign span_wide = EW'(hi_in) - EW'(lo_in) + EW'(1);
    assign range_bad = (hi_in < lo_in) || (span_wide > EW'(SPAN_MAX));

    assign in_ready   = (state_reg == T_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign core_start = accept && !range_bad;

    sps_core #(
        .VB       (VB),
        .SPAN_MAX (SPAN_MAX),
        .ROOT_MAX (ROOT_MAX)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_start),
        .lo    (lo_reg),
        .hi    (hi_reg),
        .span  (span_reg),
        .done  (core_done),
        .count (core_count)
    );

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        span_next      = span_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    lo_next   = lo_in;
                    hi_next   = hi_in;
                    span_next = SW'(span_wide);
                    err_next  = range_bad;
                    // A bad range skips the sieve and reports at once.
                    state_next = range_bad ? T_HOLD : T_RUN;
                end
            end

            T_RUN:
            begin
                if (core_done)
                begin
                    state_next = T_HOLD;
                end
            end

            T_HOLD:
            begin
                // The core keeps its count stable until the next request.
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.range_error = err_reg;
                    out_data_next.prime_count = err_reg ? '0 : COUNT_W'(core_count);
                    state_next                = T_IDLE;
                end
            end

            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        span_reg     <= span_next;
        err_reg      <= err_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- verif/segmented_prime_sieve_count_top_tb.sv -----
// ----------------------------------------------------------------------------
// Segmented prime sieve counter testbench
// Sends range requests to the prime counter and checks each result against a
// sieve computed inside the testbench. Directed corner cases come first,
// followed by mostly small random ranges. The request side idles in bursts and
// the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module segmented_prime_sieve_count_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sps_pkg::*;

    // These match the block's default parameters. The golden sieve sizes its
    // flag arrays from them.
    localparam int VALUE_BITS = VALUE_BITS_DEF;
    localparam int SPAN_MAX   = SPAN_MAX_DEF;
    localparam int ROOT_MAX   = ROOT_MAX_DEF;
    localparam int unsigned VALUE_MAX = (1 << RANGE_W) - 1;

    // The longest idle stretch on each side. The cycle limit budgets for both.
    localparam int MAX_SEND_GAP  = 15;
    localparam int MAX_RECV_STALL = 20;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // Requests waiting to be driven, and the results owed by the block. The
    // results are kept in acceptance order.
    in_item_t  pending_requests[$];
    out_item_t expected_counts[$];

    int     mismatch_count = 0;
    longint cycle_count = 0;
    longint cycle_limit = 64'h7fff_ffff_ffff;
    longint cycle_budget = 0;

    // These are the golden sieve's working flags. Like the block's memories,
    // they are refilled on every request.
    bit root_mark [0:ROOT_MAX-1];
    bit span_mark [0:SPAN_MAX-1];

    segmented_prime_sieve_count_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // The clock has a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned int_sqrt_trunc(longint unsigned v);
        return v[31:0];
    endfunction

    // This returns the largest r with r*r <= n. It works one bit at a time,
    // from the top.
    function automatic int unsigned int_sqrt(int unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 16; b >= 0; b--)
        begin
            t = r + (64'd1 << b);
            if (t * t <= n)
                r = t;
        end
        return int_sqrt_trunc(r);
    endfunction

    // This is the golden segmented sieve. A reversed range or an oversized
    // range gives an error with a zero count. Otherwise it sieves the small
    // primes below floor(sqrt(high)) + 1 and strikes their multiples in the
    // range. A strike never starts below twice the prime, so small primes that
    // fall inside the range survive. Last, it counts the surviving values of
    // two and above.
    function automatic out_item_t count_primes_in_range(in_item_t req);
        int unsigned lo;
        int unsigned hi;
        int unsigned span;
        int unsigned lim;
        int unsigned first;
        int unsigned tally;
        out_item_t   res;
        lo  = req.range_low;
        hi  = req.range_high;
        res = '0;
        if (hi < lo || hi - lo + 1 > SPAN_MAX)
        begin
            res.range_error = 1'b1;
            return res;
        end
        span = hi - lo + 1;
        lim  = int_sqrt(hi) + 1;
        if (lim > ROOT_MAX)
            lim = ROOT_MAX;

        for (int unsigned m = 0; m < ROOT_MAX; m++)
            root_mark[m] = 1'b1;
        root_mark[0] = 1'b0;
        if (lim > 1)
            root_mark[1] = 1'b0;
        for (int unsigned p = FIRST_PRIME; p * p < lim; p++)
            if (root_mark[p])
                for (int unsigned m = p * p; m < lim; m += p)
                    root_mark[m] = 1'b0;

        for (int unsigned m = 0; m < SPAN_MAX; m++)
            span_mark[m] = 1'b1;
        for (int unsigned p = FIRST_PRIME; p < lim; p++)
        begin
            if (root_mark[p])
            begin
                first = ((lo + p - 1) / p) * p;
                if (first < p * FIRST_PRIME)
                    first = p * FIRST_PRIME;
                for (int unsigned m = first; m <= hi; m += p)
                    span_mark[m - lo] = 1'b0;
            end
        end

        tally = 0;
        for (int unsigned m = 0; m < span; m++)
            if (span_mark[m] && lo + m >= FIRST_PRIME)
                tally++;
        res.prime_count = tally[COUNT_W-1:0];
        return res;
    endfunction

    // This gives a generous upper bound on the cycles one request may take.
    // It follows the passes of the block's sequencer. The prime count
    // is bounded by half the root limit, and the sum of span/p by three spans.
    function automatic longint request_cycle_bound(int unsigned lo, int unsigned hi);
        longint span;
        longint lim;
        if (hi < lo || hi - lo + 1 > SPAN_MAX)
            return 16;
        span = hi - lo + 1;
        lim  = int_sqrt(hi) + 1;
        if (lim > ROOT_MAX)
            lim = ROOT_MAX;
        return 64 + VALUE_BITS + 5 * span + lim + (lim / 2 + 1) * (VALUE_BITS + 6);
    endfunction

    // This queues one request and adds its worst case to the run's budget. The
    // worst case includes the longest sender gap and the longest receiver
    // stall.
    task automatic add_request(int unsigned lo, int unsigned hi);
        in_item_t req;
        req.range_low  = lo[RANGE_W-1:0];
        req.range_high = hi[RANGE_W-1:0];
        pending_requests.push_back(req);
        cycle_budget += request_cycle_bound(lo, hi) + MAX_SEND_GAP + MAX_RECV_STALL;
    endtask

    task automatic report_mismatch(string what);
        $display("ERROR cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Request driver. A new request is presented only when the slot is free,
    // that is, when nothing is shown or the current transaction is accepted at
    // this edge. Requests go out in bursts of random length. Between bursts
    // comes a random gap, which is sometimes zero, so that back-to-back
    // stretches occur too. The expected result is computed at the moment a
    // request is accepted.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_counts.push_back(count_primes_in_range(in_data));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    in_data  <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(8, 1);
                        gap_left   = ($urandom_range(3, 0) == 0) ? 0 :
                                     $urandom_range(MAX_SEND_GAP, 1);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result receiver. Ready runs for a random number of cycles and then drops
    // for a random stall. The stall is often zero, which gives stretches
    // without backpressure.
    int ready_left = 0;
    int stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (ready_left > 0)
                ready_left--;
            else
            begin
                ready_left = $urandom_range(10, 0);
                stall_left = ($urandom_range(2, 0) == 0) ? 0 :
                             $urandom_range(MAX_RECV_STALL, 1);
            end
        end
    end

    // Result monitor. Each accepted result transaction is compared field by
    // field with the oldest outstanding expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_counts.size() == 0)
                report_mismatch($sformatf("result with none outstanding: count %0d err %0b",
                                          out_data.prime_count, out_data.range_error));
            else
            begin
                want = expected_counts.pop_front();
                if (out_data.prime_count !== want.prime_count)
                    report_mismatch($sformatf("prime_count got %0d want %0d",
                                              out_data.prime_count, want.prime_count));
                if (out_data.range_error !== want.range_error)
                    report_mismatch($sformatf("range_error got %0b want %0b",
                                              out_data.range_error, want.range_error));
            end
        end
    end

    // This is the watchdog. If the run outlasts its budget, it is treated as a
    // hang.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int unsigned lo;
        int unsigned hi;
        int unsigned sel;

        // Directed cases. The first ones are the lowest values, where zero
        // and one must never count and the small primes must survive their own
        // strikes.
        add_request(0, 0);
        add_request(0, 1);
        add_request(0, 2);
        add_request(2, 2);
        add_request(3, 3);
        add_request(4, 4);
        add_request(1, 100);
        add_request(65535, 65537);
        // These are reversed ranges, including the most extreme one.
        add_request(5, 4);
        add_request(VALUE_MAX, 0);
        // This range is one value wider than the store, and the next spans the
        // whole value space.
        add_request(0, SPAN_MAX);
        add_request(0, VALUE_MAX);
        // These ranges exactly fill the store, once at the bottom and once at
        // the very top.
        add_request(0, SPAN_MAX - 1);
        add_request(VALUE_MAX - SPAN_MAX + 1, VALUE_MAX);
        // These are single values and short ranges near the top, where the
        // root sieve is at its largest. One of them is the square of the
        // largest root prime.
        add_request(VALUE_MAX, VALUE_MAX);
        add_request(VALUE_MAX - 2, VALUE_MAX - 2);
        add_request(4093 * 4093, 4093 * 4093);
        add_request(VALUE_MAX - 255, VALUE_MAX);
        // These are alternating bit patterns in both fields.
        add_request(24'hAAAAAA, 24'hAAAAAA + 200);
        add_request(24'h555555, 24'h555555 + 200);

        // The random part is mostly small ranges low in the value space, which
        // are quick. A few requests sit anywhere in the 24-bit space with a
        // short span, some are medium, and some are error cases with fully
        // random values.
        for (int n = 0; n < 85; n++)
        begin
            sel = $urandom_range(99, 0);
            if (sel < 10)
            begin
                if ($urandom_range(1, 0) == 1)
                begin
                    lo = $urandom_range(VALUE_MAX, 1);
                    hi = $urandom_range(lo - 1, 0);
                end
                else
                begin
                    lo = $urandom_range(VALUE_MAX - SPAN_MAX, 0);
                    hi = $urandom_range(VALUE_MAX, lo + SPAN_MAX);
                end
            end
            else if (sel < 16)
            begin
                lo = $urandom() & VALUE_MAX;
                hi = lo + $urandom_range(255, 0);
                if (hi > VALUE_MAX)
                    hi = VALUE_MAX;
            end
            else if (sel < 20)
            begin
                lo = $urandom_range(1 << 20, 0);
                hi = lo + $urandom_range(4095, 0);
            end
            else
            begin
                lo = ($urandom_range(3, 0) == 0) ? $urandom_range(8, 0) :
                     $urandom_range(65535, 0);
                hi = lo + $urandom_range(255, 0);
            end
            add_request(lo, hi);
        end

        // The limit allows four times the summed budget of all requests, plus a margin for the reset.
        cycle_limit = 4 * cycle_budget + 20000;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // These checks run at the falling edge, once the driver's updates at
        // the rising edge have settled.
        while (pending_requests.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_counts.size() != 0)
            @(negedge clk);
        // After the last result, a short wait catches any extra result
        // transactions.
        repeat (50) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
